FILE: src/sst_pkg.sv
// Package for the sorted set table: command codes, channel payload types
// and the control word broadcast to the row of cells. No dependencies.
package sst_pkg;

   // Command codes carried in the request payload.
   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_REMOVE  = 3'd1;
   localparam logic [2:0] CMD_TEST    = 3'd2;
   localparam logic [2:0] CMD_POP_MIN = 3'd3;
   localparam logic [2:0] CMD_POP_MAX = 3'd4;

   // Width of the count field in a response.
   localparam int unsigned COUNT_W = 5;

   // Request payload: one command and its operand.
   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic                 ok;
      logic signed [31:0]   taken_value;
      logic [COUNT_W-1:0]   count;
      logic signed [31:0]   smallest;
      logic signed [31:0]   largest;
      logic                 is_empty;
   } rsp_type;

   // Control word broadcast to every cell for one cycle.
   typedef struct packed {
      logic ins;      // insert the operand at its sorted position
      logic del;      // close the gap at the matching element
      logic pop_min;  // shift the whole row down by one
      logic pop_max;  // drop the top element
   } cell_ctl_type;

endpackage

FILE: src/sst_chan_if.sv
// Valid/ready channel interface used for both the request and response sides.
// Depends on the payload types of sst_pkg, passed in as a type parameter.
interface sst_chan_if #(
   parameter type payload_type = sst_pkg::req_type
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/sst_cell.sv
// One cell of the sorted row: holds one element and its occupancy flag.
// Depends on sst_pkg for the broadcast control word.
module sst_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  sst_pkg::cell_ctl_type     ctl,
   input  logic signed [31:0]        operand,
   input  logic signed [31:0]        left_value,
   input  logic                      left_valid,
   input  logic                      left_lt,
   input  logic signed [31:0]        right_value,
   input  logic                      right_valid,
   output logic signed [31:0]        value,
   output logic                      valid,
   output logic                      lt,
   output logic                      eq,
   output logic                      is_last
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               valid_ff;
   logic               valid_in;

   // Compare the held element against the operand of the current transfer.
   assign lt      = valid_ff && (value_ff < operand);
   assign eq      = valid_ff && (value_ff == operand);
   assign is_last = valid_ff && !right_valid;
   assign value   = value_ff;
   assign valid   = valid_ff;

   // Next contents: keep, take the operand, or take a neighbour's element.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.ins) begin
         valid_in = left_valid;
         if (!lt) begin
            value_in = left_lt ? operand : left_value;
         end
      end else if (ctl.del) begin
         valid_in = right_valid;
         if (!lt) begin
            value_in = right_value;
         end
      end else if (ctl.pop_min) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctl.pop_max) begin
         valid_in = right_valid;
      end
   end

   // Element storage needs no reset; occupancy does.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: src/sorted_set_table.sv
// Top level of the sorted set table: a row of compare-and-shift cells plus
// the command decode and response register. Depends on sst_pkg, sst_chan_if, sst_cell.
//
//   Channel   Direction  Handshake      Payload
//   req_ch    in         valid/ready    cmd, value
//   rsp_ch    out        valid/ready    ok, taken_value, count, smallest, largest, is_empty
//
// For each command the row of cells updates in the cycle of the transfer, and
// the response is formed from the updated row once the response register is free.
// Reset empties the set at once; no clearing pass is needed.
// A waiting response does not block the next request; that request's
// response waits in the pending stage until the response register is free.
module sorted_set_table #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   sst_chan_if.sink   req_ch,
   sst_chan_if.source rsp_ch
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   sst_pkg::cell_ctl_type ctl;

   logic signed [31:0] cell_value [CAPACITY];
   logic               cell_valid [CAPACITY];
   logic               cell_lt    [CAPACITY];
   logic               cell_eq    [CAPACITY];
   logic               cell_last  [CAPACITY];

   logic               accept;
   logic               found;
   logic               full;
   logic               nonempty;
   logic signed [31:0] last_value;

   logic               pend_ff;
   logic               pend_in;
   logic               ok_ff;
   logic               ok_in;
   logic signed [31:0] taken_ff;
   logic signed [31:0] taken_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   sst_pkg::rsp_type   out_data_ff;
   sst_pkg::rsp_type   out_data_in;
   logic               out_load;
   logic [CW+sst_pkg::COUNT_W-1:0] count_ext;

   // Row of cells, each wired to its two neighbours.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] lv;
      logic               lval;
      logic               llt;
      logic signed [31:0] rv;
      logic               rval;

      if (i == 0) begin : g_first
         assign lv   = req_ch.data.value;
         assign lval = 1'b1;
         assign llt  = 1'b1;
      end else begin : g_inner_left
         assign lv   = cell_value[i-1];
         assign lval = cell_valid[i-1];
         assign llt  = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_final
         assign rv   = cell_value[i];
         assign rval = 1'b0;
      end else begin : g_inner_right
         assign rv   = cell_value[i+1];
         assign rval = cell_valid[i+1];
      end

      sst_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .operand     (req_ch.data.value),
         .left_value  (lv),
         .left_valid  (lval),
         .left_lt     (llt),
         .right_value (rv),
         .right_valid (rval),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i]),
         .is_last     (cell_last[i])
      );
   end

   // Membership and the top element, gathered across the row.
   always_comb begin
      found      = 1'b0;
      last_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found      = found | cell_eq[i];
         last_value = last_value | (cell_value[i] & {32{cell_last[i]}});
      end
   end

   assign full     = (count_ff == CW'(CAPACITY));
   assign nonempty = (count_ff != '0);

   // A new request is taken whenever no response is still being formed.
   assign req_ch.ready = !pend_ff;
   assign accept       = req_ch.valid && !pend_ff;

   // Command decode for the cells, the status bits and the count.
   always_comb begin
      ctl      = '0;
      ok_in    = ok_ff;
      taken_in = taken_ff;
      count_in = count_ff;
      if (accept) begin
         ok_in    = 1'b0;
         taken_in = '0;
         case (req_ch.data.cmd)
            sst_pkg::CMD_ADD: begin
               if (!found && !full) begin
                  ctl.ins  = 1'b1;
                  ok_in    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            sst_pkg::CMD_REMOVE: begin
               if (found) begin
                  ctl.del  = 1'b1;
                  ok_in    = 1'b1;
                  count_in = count_ff - CW'(1);
               end
            end
            sst_pkg::CMD_TEST: begin
               ok_in = found;
            end
            sst_pkg::CMD_POP_MIN: begin
               if (nonempty) begin
                  ctl.pop_min = 1'b1;
                  ok_in       = 1'b1;
                  taken_in    = cell_value[0];
                  count_in    = count_ff - CW'(1);
               end
            end
            sst_pkg::CMD_POP_MAX: begin
               if (nonempty) begin
                  ctl.pop_max = 1'b1;
                  ok_in       = 1'b1;
                  taken_in    = last_value;
                  count_in    = count_ff - CW'(1);
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   // The response register loads once the pending result has somewhere to go.
   assign out_load  = pend_ff && (!out_valid_ff || rsp_ch.ready);
   assign count_ext = {{sst_pkg::COUNT_W{1'b0}}, count_ff};

   always_comb begin
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         pend_in                 = 1'b0;
         out_valid_in            = 1'b1;
         out_data_in.ok          = ok_ff;
         out_data_in.taken_value = taken_ff;
         out_data_in.count       = count_ext[sst_pkg::COUNT_W-1:0];
         out_data_in.smallest    = nonempty ? cell_value[0] : 32'sd0;
         out_data_in.largest     = nonempty ? last_value : 32'sd0;
         out_data_in.is_empty    = !nonempty;
      end
      if (accept) begin
         pend_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      taken_ff    <= taken_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

endmodule
